/* design/flfc_pkg.sv */
// flfc_pkg: shared constants and types for the flag framed crc16 limit receiver
// no dependencies; imported by flfc_crc_byte, flag_frame_crc16_limit_receiver and its testbench
`timescale 1ns / 1ps

package flfc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned COUNT_W    = 4;

    localparam logic [BYTE_W-1:0]  FLAG_BYTE = 8'h7E;
    localparam logic [CRC_W-1:0]   CRC_POLY  = 16'h8408;
    localparam logic [CRC_W-1:0]   CRC_INIT  = 16'hFFFF;

    // content byte positions: 8 payload bytes, then the two check bytes
    localparam logic [COUNT_W-1:0] PAYLOAD_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] CHECK_HI_POS  = 4'd9;
    localparam logic [COUNT_W-1:0] NEED_BYTES    = 4'd10;

    typedef enum logic [1:0] {
        ST_SHORT    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_ACCEPT   = 2'd2
    } t_frame_status;

endpackage

/* design/flfc_crc_byte.sv */
// flfc_crc_byte: one byte of reflected crc16 update, unrolled into combinational logic
// depends on flfc_pkg
`timescale 1ns / 1ps

module flfc_crc_byte (
    input  logic [flfc_pkg::CRC_W-1:0]  i_crc,
    input  logic [flfc_pkg::BYTE_W-1:0] i_byte,
    output logic [flfc_pkg::CRC_W-1:0]  o_crc
);
    import flfc_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int b = 0; b < BYTE_W; b++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

/* design/flag_frame_crc16_limit_receiver.sv */
// flag_frame_crc16_limit_receiver: flag delimited frame receiver, crc16/x-25 check,
// stores two 32-bit limit words from accepted frames
// depends on flfc_pkg and flfc_crc_byte
`timescale 1ns / 1ps

//  channel  | valid        | stall        | beat contents
//  ---------+--------------+--------------+---------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_rx_byte
//  output   | o_out_valid  | i_out_stall  | o_frame_status, o_lower_limit, o_upper_limit,
//           |              |              | o_received_check, o_computed_check
//
//  one byte per cycle; each byte updates the frame state in the cycle it is taken
//  a closing flag loads the result register, shown from the next cycle on
//  the input stalls only while a result sits in the result register and the
//  output is stalled; otherwise an offered byte is taken every cycle
//  synchronous active-low reset: hunting for a flag, limits zero, no result pending

module flag_frame_crc16_limit_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [flfc_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_frame_status,
    output logic [flfc_pkg::WORD_W-1:0]  o_lower_limit,
    output logic [flfc_pkg::WORD_W-1:0]  o_upper_limit,
    output logic [flfc_pkg::CRC_W-1:0]   o_received_check,
    output logic [flfc_pkg::CRC_W-1:0]   o_computed_check
);
    import flfc_pkg::*;

    // frame state
    logic                   r_in_frame,   n_in_frame;
    logic [COUNT_W-1:0]     r_count,      n_count;
    logic [CRC_W-1:0]       r_crc,        n_crc;
    logic [2*WORD_W-1:0]    r_payload,    n_payload;
    logic [CRC_W-1:0]       r_check,      n_check;
    logic [WORD_W-1:0]      r_lower,      n_lower;
    logic [WORD_W-1:0]      r_upper,      n_upper;

    // result register
    logic                   r_out_valid,  n_out_valid;
    t_frame_status          r_status,     n_status;
    logic [WORD_W-1:0]      r_res_lower,  n_res_lower;
    logic [WORD_W-1:0]      r_res_upper,  n_res_upper;
    logic [CRC_W-1:0]       r_res_rx,     n_res_rx;
    logic [CRC_W-1:0]       r_res_calc,   n_res_calc;

    logic                   w_accept;
    logic                   w_flag;
    logic [CRC_W-1:0]       w_crc_next;
    logic [CRC_W-1:0]       w_calc;
    logic                   w_long;
    logic                   w_match;

    flfc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_rx_byte),
        .o_crc  (w_crc_next)
    );

    // result register frees up when the pending result is taken this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_flag     = (i_rx_byte == FLAG_BYTE);

    // count saturates at ten, so equality means a full frame
    assign w_long  = (r_count == NEED_BYTES);
    assign w_calc  = ~r_crc;
    assign w_match = (r_check == w_calc);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_crc       = r_crc;
        n_payload   = r_payload;
        n_check     = r_check;
        n_lower     = r_lower;
        n_upper     = r_upper;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_res_lower = r_res_lower;
        n_res_upper = r_res_upper;
        n_res_rx    = r_res_rx;
        n_res_calc  = r_res_calc;

        if (w_accept) begin
            if (!r_in_frame) begin
                // hunting: an opening flag starts a fresh frame
                if (w_flag) begin
                    n_in_frame = 1'b1;
                    n_count    = '0;
                    n_crc      = CRC_INIT;
                end
            end else if (w_flag) begin
                // closing flag: give a result
                n_in_frame  = 1'b0;
                n_count     = '0;
                n_out_valid = 1'b1;
                n_res_rx    = '0;
                n_res_calc  = '0;
                n_status    = ST_SHORT;
                if (w_long) begin
                    n_res_rx   = r_check;
                    n_res_calc = w_calc;
                    if (w_match) begin
                        n_status = ST_ACCEPT;
                        n_lower  = r_payload[WORD_W-1:0];
                        n_upper  = r_payload[2*WORD_W-1:WORD_W];
                    end else begin
                        n_status = ST_MISMATCH;
                    end
                end
                n_res_lower = (w_long && w_match) ? r_payload[WORD_W-1:0] : r_lower;
                n_res_upper = (w_long && w_match) ? r_payload[2*WORD_W-1:WORD_W] : r_upper;
            end else begin
                // content byte
                if (r_count < PAYLOAD_BYTES) begin
                    n_crc     = w_crc_next;
                    n_payload = {i_rx_byte, r_payload[2*WORD_W-1:BYTE_W]};
                end else if (r_count == PAYLOAD_BYTES) begin
                    n_check = {r_check[CRC_W-1:BYTE_W], i_rx_byte};
                end else if (r_count == CHECK_HI_POS) begin
                    n_check = {i_rx_byte, r_check[BYTE_W-1:0]};
                end
                if (!w_long) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_lower     <= '0;
            r_upper     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_lower     <= n_lower;
            r_upper     <= n_upper;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_payload   <= n_payload;
        r_check     <= n_check;
        r_status    <= n_status;
        r_res_lower <= n_res_lower;
        r_res_upper <= n_res_upper;
        r_res_rx    <= n_res_rx;
        r_res_calc  <= n_res_calc;
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_status   = r_status;
    assign o_lower_limit    = r_res_lower;
    assign o_upper_limit    = r_res_upper;
    assign o_received_check = r_res_rx;
    assign o_computed_check = r_res_calc;

endmodule

/* dv/tb_flag_frame_crc16_limit_receiver.sv */
// tb_flag_frame_crc16_limit_receiver: self-checking bench for the flag framed crc16 limit receiver
// predicts each closing-flag result from its own frame tracker and compares every output beat
// depends on flfc_pkg and the flag_frame_crc16_limit_receiver rtl
`timescale 1ns / 1ps

module tb_flag_frame_crc16_limit_receiver;

    import flfc_pkg::*;

    // generous bound: all test traffic at worst-case gaps plus stalls and the long hold-off
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_OFF_LEN = 400;

    // one expected result beat
    typedef struct packed {
        t_frame_status        status;
        logic [WORD_W-1:0]    lower;
        logic [WORD_W-1:0]    upper;
        logic [CRC_W-1:0]     rx_check;
        logic [CRC_W-1:0]     calc_check;
    } t_frame_result;

    // dut ports, all inputs driven to known values from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]  i_rx_byte   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_frame_status;
    logic [WORD_W-1:0]  o_lower_limit;
    logic [WORD_W-1:0]  o_upper_limit;
    logic [CRC_W-1:0]   o_received_check;
    logic [CRC_W-1:0]   o_computed_check;

    // frame tracker state, mirrors what the receiver should hold
    logic               trk_in_frame  = 1'b0;
    logic [COUNT_W-1:0] trk_count     = '0;
    logic [CRC_W-1:0]   trk_crc       = CRC_INIT;
    logic [63:0]        trk_payload   = '0;
    logic [CRC_W-1:0]   trk_check     = '0;
    logic [WORD_W-1:0]  stored_lower  = '0;
    logic [WORD_W-1:0]  stored_upper  = '0;

    t_frame_result      expected_frames [$];
    logic [BYTE_W-1:0]  frame_body [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int framed_bytes   = 0;   // bytes the receiver acts on; dropped hunt bytes not counted
    int mismatch_count = 0;
    int cycle_count    = 0;

    flag_frame_crc16_limit_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_status   (o_frame_status),
        .o_lower_limit    (o_lower_limit),
        .o_upper_limit    (o_upper_limit),
        .o_received_check (o_received_check),
        .o_computed_check (o_computed_check)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one byte through crc-16/x-25, lsb first with the reflected polynomial
    function automatic logic [CRC_W-1:0] crc16_x25_step(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] value);
        logic [CRC_W-1:0] acc;
        acc = crc ^ {8'h00, value};
        for (int i = 0; i < 8; i++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // advance the frame tracker by one accepted byte; a closing flag queues a result
    function automatic void track_rx_byte(input logic [BYTE_W-1:0] value);
        t_frame_result res;
        if (!trk_in_frame) begin
            // hunting: only a flag matters, and it opens a fresh frame
            if (value == FLAG_BYTE) begin
                trk_in_frame = 1'b1;
                trk_count    = '0;
                trk_crc      = CRC_INIT;
            end
            return;
        end
        if (value == FLAG_BYTE) begin
            // closing flag: short frames report zero checks and keep the limits
            trk_in_frame = 1'b0;
            res          = '0;
            if (trk_count < NEED_BYTES) begin
                res.status = ST_SHORT;
            end else begin
                res.rx_check   = trk_check;
                res.calc_check = ~trk_crc;
                if (trk_check == ~trk_crc) begin
                    stored_lower = trk_payload[31:0];
                    stored_upper = trk_payload[63:32];
                    res.status   = ST_ACCEPT;
                end else begin
                    res.status = ST_MISMATCH;
                end
            end
            res.lower = stored_lower;
            res.upper = stored_upper;
            expected_frames.push_back(res);
            trk_count = '0;
            return;
        end
        // content byte: payload first, then check low and high, extras ignored
        if (trk_count < PAYLOAD_BYTES) begin
            trk_crc     = crc16_x25_step(trk_crc, value);
            trk_payload = {value, trk_payload[63:8]};
        end else if (trk_count == PAYLOAD_BYTES) begin
            trk_check[7:0] = value;
        end else if (trk_count == CHECK_HI_POS) begin
            trk_check[15:8] = value;
        end
        if (trk_count < NEED_BYTES) begin
            trk_count = trk_count + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one beat after a random gap, return once it is taken
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (trk_in_frame || value == FLAG_BYTE) framed_bytes++;
        track_rx_byte(value);
    endtask

    // wrap frame_body in flags; close any frame left open by noise first
    task automatic send_frame();
        if (trk_in_frame) send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        foreach (frame_body[i]) send_byte(frame_body[i]);
        send_byte(FLAG_BYTE);
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_byte(8'($urandom_range(255)));
    endtask

    // lower valid, then wait until every queued result has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] pick_limit_word();
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // limits little-endian, valid check, optional single-bit damage and trailing bytes
    function automatic void build_limit_frame(input logic [WORD_W-1:0] lower,
                                              input logic [WORD_W-1:0] upper,
                                              input int extra, input bit damage);
        logic [63:0]      payload;
        logic [CRC_W-1:0] crc;
        int               pos;
        payload = {upper, lower};
        crc     = CRC_INIT;
        frame_body.delete();
        for (int i = 0; i < 8; i++) begin
            frame_body.push_back(payload[8*i +: 8]);
            crc = crc16_x25_step(crc, payload[8*i +: 8]);
        end
        crc = ~crc;
        frame_body.push_back(crc[7:0]);
        frame_body.push_back(crc[15:8]);
        if (damage) begin
            pos = $urandom_range(9);
            frame_body[pos] = frame_body[pos] ^ (8'h01 << $urandom_range(7));
        end
        repeat (extra) frame_body.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_short_frame(input int length);
        frame_body.delete();
        repeat (length) frame_body.push_back(8'($urandom_range(255)));
    endfunction

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // random stall per cycle, or a forced hold-off counted down here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) note_mismatch(what, want, got);
    endfunction

    // every taken result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                note_mismatch("result with nothing expected, status", '0, o_frame_status);
            end else begin
                want = expected_frames.pop_front();
                check_field("frame_status",   want.status,     o_frame_status);
                check_field("lower_limit",    want.lower,      o_lower_limit);
                check_field("upper_limit",    want.upper,      o_upper_limit);
                check_field("received_check", want.rx_check,   o_received_check);
                check_field("computed_check", want.calc_check, o_computed_check);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hunt bytes, empty frame, one-byte short frame, extreme limits with a trailing byte
    task automatic test_directed_edges();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        build_short_frame(0);
        send_frame();
        build_short_frame(1);
        send_frame();
        build_limit_frame(32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0);
        send_frame();
        drain_results();
    endtask

    // mostly well-formed limit frames, some damaged or short, some loose noise
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int goal);
        int start;
        int pick;
        int extra;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = framed_bytes;
        while (framed_bytes - start < goal) begin
            pick  = $urandom_range(99);
            extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            if (pick < 60) begin
                build_limit_frame(pick_limit_word(), pick_limit_word(), extra, 1'b0);
                send_frame();
            end else if (pick < 78) begin
                build_limit_frame(pick_limit_word(), pick_limit_word(), extra, 1'b1);
                send_frame();
            end else if (pick < 90) begin
                build_short_frame($urandom_range(9));
                send_frame();
            end else begin
                send_noise($urandom_range(1, 4));
            end
        end
        // sender pauses until the receiver has caught up
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0,  0,  115);
        run_random_phase(62, 0,  115);
        run_random_phase(0,  62, 115);
        run_random_phase(24, 24, 115);
    endtask

    // output held off while frames keep coming, so the result register fills and
    // the input backs up until the hold-off runs out
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = HOLD_OFF_LEN;
        repeat (3) begin
            build_short_frame(0);
            send_frame();
        end
        repeat (2) begin
            build_limit_frame(pick_limit_word(), pick_limit_word(), 0, 1'b0);
            send_frame();
        end
        build_short_frame(9);
        send_frame();
        drain_results();
    endtask

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : main_flow
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_traffic();
        test_output_hold_off();

        // let anything in flight settle before the verdict
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
